// ----- rtl/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants for the scanline span rasteriser: shape codes, register
// indexes, fixed field widths and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

  // Shape codes carried in the action field
  localparam logic [1:0] ACT_FILL    = 2'd0;
  localparam logic [1:0] ACT_OUTLINE = 2'd1;
  localparam logic [1:0] ACT_CIRCLE  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH     = 2'd2;

  // Fixed field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SIZE_W   = 12;  // rect_width, rect_height, row_step
  localparam int unsigned SCREEN_W = 13;  // screen_width, screen_height, columns, rows
  localparam int unsigned PITCH_W  = 14;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned OFFSET_W = 25;
  localparam int unsigned LENGTH_W = 13;
  localparam int unsigned COLOUR_W = 32;

  // Register reset values
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [PITCH_W-1:0]  ROW_PITCH_RST     = 14'd640;

endpackage

`default_nettype wire

// ----- rtl/ssr_if.sv -----
// ----------------------------------------------------------------------------
// ssr_if
// Valid/ready channels of the span rasteriser: the row request channel and
// the pixel run channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssr_req_if import ssr_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 11
) ();
  logic                         valid;
  logic                         ready;
  logic [ACTION_W-1:0]          action;
  logic signed [COORD_BITS-1:0] x_pos;
  logic signed [COORD_BITS-1:0] y_pos;
  logic [SIZE_W-1:0]            rect_width;
  logic [SIZE_W-1:0]            rect_height;
  logic [RADIUS_BITS-1:0]       radius;
  logic [SIZE_W-1:0]            row_step;
  logic [COLOUR_W-1:0]          colour;

  modport source (output valid, action, x_pos, y_pos, rect_width, rect_height,
                  radius, row_step, colour, input ready);
  modport sink   (input valid, action, x_pos, y_pos, rect_width, rect_height,
                  radius, row_step, colour, output ready);
endinterface

interface ssr_run_if import ssr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] word_offset;
  logic [LENGTH_W-1:0] run_length;
  logic [COLOUR_W-1:0] pixel_value;
  logic                last;

  modport source (output valid, word_offset, run_length, pixel_value, last,
                  input ready);
  modport sink   (input valid, word_offset, run_length, pixel_value, last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/scanline_span_rasterizer.sv -----
// A request passes stage 0, the square-root stages and stages A to D to its first beat.
// Throughput: one request per cycle while run.ready is high; an outline interior row
// wider than one pixel holds the output register for a second beat, stalling the pipe.
// The square root takes one pipeline stage per root bit (RADIUS_BITS stages).
// Reset (rst, synchronous) empties the pipeline and loads screen 640 x 480, pitch 640.
// ----------------------------------------------------------------------------
// scanline_span_rasterizer
// Clips one row of a filled rectangle, rectangle outline or filled circle to
// the screen and emits pixel runs as word offset, length and colour.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_span_rasterizer import ssr_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  ssr_req_if.sink                     req,
  ssr_run_if.source                   run
);

  localparam int RB = RADIUS_BITS;
  localparam int NW = 2 * RB;                           // radicand width
  localparam int CW = COORD_BITS + 4;                   // signed working width
  localparam int EW = (RB + 1 > SIZE_W) ? RB + 1 : SIZE_W;
  localparam int PW = 2 * RB + 2;                       // radicand product width

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic signed [CW-1:0] row;
    logic signed [CW-1:0] x;
    logic [SIZE_W-1:0]   wid;
    logic                interior;
    logic [COLOUR_W-1:0] colour;
  } pay_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SCREEN_W-1:0] scr_w;
  logic [SCREEN_W-1:0] scr_h;
  logic [PITCH_W-1:0]  pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= SCREEN_WIDTH_RST;
      scr_h <= SCREEN_HEIGHT_RST;
      pitch <= ROW_PITCH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: scr_h <= cfg_data[SCREEN_W-1:0];
        REG_ROW_PITCH:     pitch <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline registers and load enables
  // --------------------------------------------------------------------------
  logic              sq_v   [0:RB];
  logic [NW-1:0]     sq_rem [0:RB];
  logic [RB-1:0]     sq_q   [0:RB];
  pay_t              sq_pay [0:RB];
  logic              ld_sq  [0:RB];

  logic                 va, vb, vc, vd;
  logic                 ld_a, ld_b, ld_c, ld_d;
  logic signed [CW-1:0] xa, la;
  logic [SCREEN_W-1:0]  rowa, rowb;
  logic                 interior_a;
  logic [COLOUR_W-1:0]  colour_a, colour_b, colour_c, colour_d;
  logic [SCREEN_W-1:0]  colb;
  logic [LENGTH_W-1:0]  lenb, lenc, lend;
  logic                 two_b, two_c, two_d;
  logic [OFFSET_W-1:0]  prodc;
  logic [SCREEN_W-1:0]  colc, col_endc;
  logic [OFFSET_W-1:0]  off0, off1;
  logic                 phase;
  logic                 beat_done, item_done;

  assign beat_done = run.valid && run.ready;
  assign item_done = beat_done && (!two_d || phase);

  // A stage loads when it is empty or its contents move on this cycle
  assign ld_d = !vd || item_done;
  assign ld_c = !vc || ld_d;
  assign ld_b = !vb || ld_c;
  assign ld_a = !va || ld_b;
  assign ld_sq[RB] = !sq_v[RB] || ld_a;

  genvar j;
  generate
    for (j = 0; j < RB; j++) begin : g_ld
      assign ld_sq[j] = !sq_v[j] || ld_sq[j+1];
    end
  endgenerate

  assign req.ready = ld_sq[0];

  // --------------------------------------------------------------------------
  // Stage 0: decode, shape range check, radicand r*r - (r-i)*(r-i) = i*(2r-i)
  // --------------------------------------------------------------------------
  logic                 is_rect, is_circ, kill0, interior0;
  logic [EW-1:0]        ii, two_r, diff;
  logic [PW-1:0]        prod0;
  logic signed [CW-1:0] y_s, i_s, r_s, row0;
  pay_t                 pay0;

  always_comb begin
    is_rect = (req.action == ACT_FILL) || (req.action == ACT_OUTLINE);
    is_circ = (req.action == ACT_CIRCLE);
    ii      = EW'(req.row_step);
    two_r   = EW'({req.radius, 1'b0});
    diff    = two_r - ii;
    prod0   = PW'(diff[RB:0]) * PW'(ii[RB:0]);
    y_s     = CW'(req.y_pos);
    i_s     = $signed(CW'(req.row_step));
    r_s     = $signed(CW'(req.radius));
    row0    = is_circ ? (y_s - r_s + i_s) : (y_s + i_s);
    kill0   = !(is_rect || is_circ)
              || (is_rect && (req.row_step >= req.rect_height))
              || (is_circ && (ii >= two_r));
    interior0 = (req.action == ACT_OUTLINE) && (req.row_step != '0)
                && ((SCREEN_W'(req.row_step) + SCREEN_W'(1)) < SCREEN_W'(req.rect_height));
    pay0.act      = req.action;
    pay0.row      = row0;
    pay0.x        = CW'(req.x_pos);
    pay0.wid      = req.rect_width;
    pay0.interior = interior0;
    pay0.colour   = req.colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (ld_sq[0]) begin
      sq_v[0] <= req.valid && !kill0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_sq[0]) begin
      sq_rem[0] <= prod0[NW-1:0];
      sq_q[0]   <= '0;
      sq_pay[0] <= pay0;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one root bit per stage, most significant first.
  // Keep rem = n - q*q; try q + 2^k, which costs q*2^(k+1) + 4^k.
  // --------------------------------------------------------------------------
  generate
    for (j = 0; j < RB; j++) begin : g_sqrt
      localparam int K = RB - 1 - j;
      logic [NW:0] sub;
      logic        ge;

      assign sub = ((NW+1)'(sq_q[j]) << (K + 1)) + ((NW+1)'(1) << (2 * K));
      assign ge  = (NW+1)'(sq_rem[j]) >= sub;

      always_ff @(posedge clk) begin
        if (rst) begin
          sq_v[j+1] <= 1'b0;
        end else if (ld_sq[j+1]) begin
          sq_v[j+1] <= sq_v[j];
        end
      end

      always_ff @(posedge clk) begin
        if (ld_sq[j+1]) begin
          sq_rem[j+1] <= ge ? (sq_rem[j] - sub[NW-1:0]) : sq_rem[j];
          sq_q[j+1]   <= ge ? (sq_q[j] | (RB'(1) << K)) : sq_q[j];
          sq_pay[j+1] <= sq_pay[j];
        end
      end
    end
  endgenerate

  // --------------------------------------------------------------------------
  // Stage A: pick start and length, vertical clip, left clip
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] half_s, row_s, xa_next, la_next;
  logic                 kill_a;

  always_comb begin
    half_s = $signed(CW'(sq_q[RB]));
    row_s  = $signed(sq_pay[RB].row);
    if (sq_pay[RB].act == ACT_CIRCLE) begin
      la_next = half_s + half_s;
      xa_next = $signed(sq_pay[RB].x) - half_s;
    end else begin
      la_next = $signed(CW'(sq_pay[RB].wid));
      xa_next = $signed(sq_pay[RB].x);
    end
    kill_a = (row_s < 0) || (row_s >= $signed(CW'(scr_h)));
    if (xa_next < 0) begin
      la_next = la_next + xa_next;
      xa_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ld_a) begin
      va <= sq_v[RB] && !kill_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      xa         <= xa_next;
      la         <= la_next;
      rowa       <= row_s[SCREEN_W-1:0];
      interior_a <= sq_pay[RB].interior;
      colour_a   <= sq_pay[RB].colour;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: right clip, drop empty runs
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] w_s, end_b, lb;
  logic                 kill_b;

  always_comb begin
    w_s    = $signed(CW'(scr_w));
    end_b  = xa + la;
    lb     = (end_b >= w_s) ? (w_s - xa) : la;
    kill_b = (lb <= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ld_b) begin
      vb <= va && !kill_b;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      colb     <= xa[SCREEN_W-1:0];
      lenb     <= lb[LENGTH_W-1:0];
      rowb     <= rowa;
      two_b    <= interior_a && (lb != 1);
      colour_b <= colour_a;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: row times pitch, right end column
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (ld_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_c) begin
      prodc    <= OFFSET_W'(rowb) * OFFSET_W'(pitch);
      colc     <= colb;
      col_endc <= colb + SCREEN_W'(lenb) - SCREEN_W'(1);
      lenc     <= lenb;
      two_c    <= two_b;
      colour_c <= colour_b;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: output register; an outline interior row wider than one pixel gives two beats
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vd    <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (ld_d) begin
        vd    <= vc;
        phase <= 1'b0;
      end else if (beat_done) begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_d) begin
      off0     <= prodc + OFFSET_W'(colc);
      off1     <= prodc + OFFSET_W'(col_endc);
      lend     <= lenc;
      two_d    <= two_c;
      colour_d <= colour_c;
    end
  end

  assign run.valid       = vd;
  assign run.word_offset = phase ? off1 : off0;
  assign run.run_length  = two_d ? LENGTH_W'(1) : lend;
  assign run.pixel_value = colour_d;
  assign run.last        = !two_d || phase;

endmodule

`default_nettype wire
